// ===== sv/awdb_pkg.sv =====
package awdb_pkg;

  localparam int BinW   = 16;
  localparam int NbW    = 17;
  localparam int SrW    = 18;
  localparam int FqW    = 32;
  localparam int LgW    = 30;
  localparam int OutW   = 18;
  localparam int DivLat = 32;
  localparam int LogLat = 26;

  localparam logic [63:0] POLE_A = 64'd6952714;
  localparam logic [63:0] POLE_B = 64'd190042767;
  localparam logic [63:0] POLE_C = 64'd8921029181;
  localparam logic [63:0] POLE_D = 64'd2436196532224;

  localparam logic signed [35:0] FLOOR_LG   = -36'sd835990578;
  localparam logic signed [27:0] DB_PER_LG  = 28'sd101008905;
  localparam logic signed [35:0] NET_OFFSET = 36'sd67108864;

  localparam logic [0:0] REG_NUM_BINS    = 1'b0;
  localparam logic [0:0] REG_SAMPLE_RATE = 1'b1;

  typedef logic [LgW-1:0] lg_t;

  function automatic logic [5:0] msb_pos(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic lg_t lg2_const(input logic [63:0] x);
    logic [5:0]  p;
    logic [63:0] m;
    logic [23:0] frac;
    p    = msb_pos(x);
    m    = (p >= 6'd31) ? (x >> (p - 6'd31)) : (x << (6'd31 - p));
    frac = '0;
    for (int i = 0; i < 24; i++) begin
      m    = (m * m) >> 31;
      frac = {frac[22:0], m[32]};
      if (m[32]) m = m >> 1;
    end
    return {p, frac};
  endfunction

  localparam lg_t LG_POLE_D = lg2_const(POLE_D);

endpackage

// ===== sv/awdb_freq.sv =====
module awdb_freq (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [15:0] bin_i,
  input  logic [17:0] sample_rate_i,
  input  logic [16:0] num_bins_i,
  output logic        vld_o,
  output logic        zero_o,
  output logic [31:0] fq_o,
  output logic [63:0] sa_o,
  output logic [63:0] sb_o,
  output logic [63:0] sc_o,
  output logic [63:0] sd_o
);

  localparam int N = awdb_pkg::DivLat;

  logic        vld0_r;
  logic [33:0] num_r;
  logic [N-1:0] dvld_r;
  logic [16:0] rem_r  [N];
  logic [31:0] low_r  [N];
  logic [31:0] quo_r  [N];
  logic        sat_r  [N];
  logic        sq_vld_r, sm_vld_r;
  logic [31:0] sq_fq_r, sm_fq_r;
  logic [63:0] f2_r;
  logic        sq_zero_r, sm_zero_r;
  logic [63:0] sa_r, sb_r, sc_r, sd_r;
  logic [31:0] fq_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= 34'(bin_i) * 34'(sample_rate_i);
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_div
    logic [16:0] rem_in;
    logic [31:0] low_in, quo_in;
    logic        sat_in, vld_in, ge;
    logic [17:0] r2;

    if (j == 0) begin : g_first
      assign rem_in = {8'b0, num_r[33:25]};
      assign low_in = {num_r[24:0], 7'b0};
      assign quo_in = '0;
      assign sat_in = ({8'b0, num_r[33:25]} >= num_bins_i);
      assign vld_in = vld0_r;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign low_in = low_r[j-1];
      assign quo_in = quo_r[j-1];
      assign sat_in = sat_r[j-1];
      assign vld_in = dvld_r[j-1];
    end

    assign r2 = {rem_in, low_in[31]};
    assign ge = (r2 >= {1'b0, num_bins_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[j] <= 1'b0;
      end else if (en) begin
        dvld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? 17'(r2 - {1'b0, num_bins_i}) : r2[16:0];
        low_r[j] <= {low_in[30:0], 1'b0};
        quo_r[j] <= {quo_in[30:0], ge};
        sat_r[j] <= sat_in;
      end
    end
  end

  assign fq_sat = sat_r[N-1] ? '1 : quo_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      sm_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r <= dvld_r[N-1];
      sm_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_fq_r   <= fq_sat;
      f2_r      <= (64'(fq_sat) * 64'(fq_sat)) >> 2;
      sq_zero_r <= (fq_sat == '0);
      sm_fq_r   <= sq_fq_r;
      sm_zero_r <= sq_zero_r;
      sa_r      <= f2_r + awdb_pkg::POLE_A;
      sb_r      <= f2_r + awdb_pkg::POLE_B;
      sc_r      <= f2_r + awdb_pkg::POLE_C;
      sd_r      <= f2_r + awdb_pkg::POLE_D;
    end
  end

  assign vld_o  = sm_vld_r;
  assign zero_o = sm_zero_r;
  assign fq_o   = sm_fq_r;
  assign sa_o   = sa_r;
  assign sb_o   = sb_r;
  assign sc_o   = sc_r;
  assign sd_o   = sd_r;

endmodule

// ===== sv/awdb_log2.sv =====
module awdb_log2 (
  input  logic              clk,
  input  logic              en,
  input  logic [63:0]       x_i,
  output awdb_pkg::lg_t     lg_o
);

  localparam int N = awdb_pkg::LogLat - 2;

  logic [63:0] x_r;
  logic [5:0]  pa_r;
  logic [5:0]  pb_r;
  logic [31:0] mb_r;
  logic [31:0] m_r    [N];
  logic [23:0] frac_r [N];
  logic [5:0]  p_r    [N];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_i;
      pa_r <= awdb_pkg::msb_pos(x_i);
      pb_r <= pa_r;
      mb_r <= (pa_r >= 6'd31) ? 32'(x_r >> (pa_r - 6'd31)) : 32'(x_r << (6'd31 - pa_r));
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_sq
    logic [31:0] m_in;
    logic [23:0] f_in;
    logic [5:0]  p_in;
    logic [63:0] sq;
    logic [32:0] t;

    if (j == 0) begin : g_first
      assign m_in = mb_r;
      assign f_in = '0;
      assign p_in = pb_r;
    end else begin : g_next
      assign m_in = m_r[j-1];
      assign f_in = frac_r[j-1];
      assign p_in = p_r[j-1];
    end

    assign sq = 64'(m_in) * 64'(m_in);
    assign t  = sq[63:31];

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j]    <= t[32] ? t[32:1] : t[31:0];
        frac_r[j] <= {f_in[22:0], t[32]};
        p_r[j]    <= p_in;
      end
    end
  end

  assign lg_o = {p_r[N-1], frac_r[N-1]};

endmodule

// ===== sv/awdb_db.sv =====
module awdb_db #(
  parameter int DB_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic               zero_i,
  input  awdb_pkg::lg_t      lf_i,
  input  awdb_pkg::lg_t      la_i,
  input  awdb_pkg::lg_t      lb_i,
  input  awdb_pkg::lg_t      lc_i,
  input  awdb_pkg::lg_t      ld_i,
  output logic               vld_o,
  output logic signed [17:0] db_o,
  output logic               floor_o
);

  localparam int S = 48 - DB_FRAC_BITS;
  localparam logic [59:0] HALF = 60'(1) << (S - 1);
  localparam logic signed [63:0] TWO_DB   = 64'sd2 <<< DB_FRAC_BITS;
  localparam logic signed [63:0] FLOOR_DB = -(64'sd70 <<< DB_FRAC_BITS);
  localparam logic signed [63:0] OUT_MAX  = 64'sd131071;
  localparam logic signed [63:0] OUT_MIN  = -64'sd131072;

  logic [2:0]         vld_r;
  logic signed [35:0] l_r;
  logic               z1_r, fl_r, fl3_r;
  logic signed [59:0] prod_r;
  logic signed [17:0] db_r;
  logic signed [35:0] l_nxt;
  logic [30:0]        bc;
  logic [59:0]        mag, rs;
  logic signed [63:0] rv, db_nxt;

  assign bc    = (31'(lb_i) + 31'(lc_i)) >> 1;
  assign l_nxt = 36'(awdb_pkg::LG_POLE_D) + (36'(lf_i) <<< 2) - 36'(la_i)
                 - 36'(bc) - 36'(ld_i) - awdb_pkg::NET_OFFSET;

  assign mag = prod_r[59] ? 60'(-prod_r) : 60'(prod_r);
  assign rs  = (mag + HALF) >> S;
  assign rv  = prod_r[59] ? -64'(rs) : 64'(rs);

  always_comb begin
    db_nxt = fl_r ? FLOOR_DB : (rv + TWO_DB);
    if (db_nxt > OUT_MAX) db_nxt = OUT_MAX;
    if (db_nxt < OUT_MIN) db_nxt = OUT_MIN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r    <= l_nxt;
      z1_r   <= zero_i;
      fl_r   <= z1_r || (l_r < awdb_pkg::FLOOR_LG);
      prod_r <= 60'(signed'(l_r[31:0]) * awdb_pkg::DB_PER_LG);
      fl3_r  <= fl_r;
      db_r   <= 18'(db_nxt);
    end
  end

  assign vld_o   = vld_r[2];
  assign db_o    = db_r;
  assign floor_o = fl3_r;

endmodule

// ===== sv/a_weighting_db_per_bin.sv =====
// A-weighting gain in dB for one spectral bin per clock when not stalled. The bin
// frequency is bin_index * sample_rate / (2 * num_bins); the result is
// 20*log10(R(f)) + 2 dB with DB_FRAC_BITS fraction bits, or the -70 dB floor with
// at_floor set when the response falls below 1e-15 (bin 0 included). The pipeline
// takes a new item every cycle while in_ready is high. It is built from a 32-stage
// bit-per-stage divider for the frequency, four pole sums, five parallel 26-stage
// logarithm lanes and three stages of dB conversion, then an output register with
// one skid entry. Configuration must be written only while the pipeline is empty.
module a_weighting_db_per_bin #(
  parameter int DB_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_bin_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_weight_db,
  output logic               out_at_floor,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [17:0]        cfg_wdata
);

  localparam int L = awdb_pkg::LogLat;

  logic [16:0] num_bins_r;
  logic [17:0] sample_rate_r;
  logic [16:0] nb_eff;
  logic        en;

  logic        f_vld, f_zero;
  logic [31:0] f_fq;
  logic [63:0] sa, sb, sc, sd;
  awdb_pkg::lg_t lf, la, lb, lc, ld;
  logic [L-1:0] dvld_r, dzero_r;

  logic               r_vld, r_fl;
  logic signed [17:0] r_db;
  logic               out_vld_r, skid_vld_r;
  logic signed [17:0] out_db_r, skid_db_r;
  logic               out_fl_r, skid_fl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r    <= 17'd1024;
      sample_rate_r <= 18'd44100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        awdb_pkg::REG_NUM_BINS:    num_bins_r    <= cfg_wdata[16:0];
        awdb_pkg::REG_SAMPLE_RATE: sample_rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nb_eff   = (num_bins_r == '0) ? 17'd1 : num_bins_r;
  assign en       = !skid_vld_r;
  assign in_ready = en && rst_n;

  awdb_freq u_freq (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .vld_i         (in_valid && en),
    .bin_i         (in_bin_index),
    .sample_rate_i (sample_rate_r),
    .num_bins_i    (nb_eff),
    .vld_o         (f_vld),
    .zero_o        (f_zero),
    .fq_o          (f_fq),
    .sa_o          (sa),
    .sb_o          (sb),
    .sc_o          (sc),
    .sd_o          (sd)
  );

  awdb_log2 u_lf (.clk(clk), .en(en), .x_i({32'b0, f_fq}), .lg_o(lf));
  awdb_log2 u_la (.clk(clk), .en(en), .x_i(sa), .lg_o(la));
  awdb_log2 u_lb (.clk(clk), .en(en), .x_i(sb), .lg_o(lb));
  awdb_log2 u_lc (.clk(clk), .en(en), .x_i(sc), .lg_o(lc));
  awdb_log2 u_ld (.clk(clk), .en(en), .x_i(sd), .lg_o(ld));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
    end else if (en) begin
      dvld_r <= {dvld_r[L-2:0], f_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dzero_r <= {dzero_r[L-2:0], f_zero};
    end
  end

  awdb_db #(.DB_FRAC_BITS(DB_FRAC_BITS)) u_db (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (dvld_r[L-1]),
    .zero_i  (dzero_r[L-1]),
    .lf_i    (lf),
    .la_i    (la),
    .lb_i    (lb),
    .lc_i    (lc),
    .ld_i    (ld),
    .vld_o   (r_vld),
    .db_o    (r_db),
    .floor_o (r_fl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || out_ready) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= en && r_vld;
        end
      end else if (en && r_vld) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_db_r <= skid_db_r;
        out_fl_r <= skid_fl_r;
      end else begin
        out_db_r <= r_db;
        out_fl_r <= r_fl;
      end
    end else if (en && r_vld) begin
      skid_db_r <= r_db;
      skid_fl_r <= r_fl;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_weight_db = out_db_r;
  assign out_at_floor  = out_fl_r;

endmodule
